/* rtl/fmqd_pkg.sv */
// Shared types and constants of the FM quadrature demodulator.
`default_nettype none

package fmqd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int THRESH_BITS = 15;
    localparam int OUT_BITS    = 24;
    localparam int OUT_FRAC    = 15;
    localparam int QUO_BITS    = OUT_BITS + 1;
    localparam int CNT_BITS    = $clog2(QUO_BITS);
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int NUM_BITS    = PROD_BITS + 1;
    localparam int REM_BITS    = PROD_BITS + OUT_BITS;
    localparam int CMP_BITS    = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(256);
    localparam logic [OUT_BITS-1:0]    OUT_MAX      = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0]    OUT_MIN      = {1'b1, {(OUT_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] in_phase;
        logic signed [SAMPLE_BITS-1:0] quadrature;
    } t_in_req;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] demod_value;
        logic                       held;
    } t_out_req;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] in_phase;
        logic signed [SAMPLE_BITS-1:0] quadrature;
        logic signed [SAMPLE_BITS-1:0] prev_in_phase;
        logic signed [SAMPLE_BITS-1:0] prev_quadrature;
        logic                          above;
    } t_fmqd_job;

endpackage

`default_nettype wire

/* rtl/fm_quadrature_demodulator.sv */
// Top level of the FM quadrature demodulator (cross-product discriminator).
//
//  Channel   Direction  Handshake                  Payload
//  in        input      i_in_valid / o_in_ready    i_in_req  (in_phase, quadrature)
//  out       output     o_out_valid / i_out_ready  o_out_req (demod_value, held)
//  cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_data (magnitude threshold)
//
// A sample above the threshold passes through the back end in order: load, the four
// products on the single multiplier, the restoring divider, and the write of the output
// register once the output is free. A sample below the threshold skips the arithmetic.
// Reset is synchronous; it sets the threshold to 1/128 and clears the stored sample
// and held value. A two-entry queue lets the front end take samples while the back
// end works or its result waits on the output.
`default_nettype none

module fm_quadrature_demodulator (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  fmqd_pkg::t_in_req                i_in_req,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output fmqd_pkg::t_out_req               o_out_req,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [fmqd_pkg::THRESH_BITS-1:0]  i_cfg_data
);

    logic                front_valid;
    logic                front_ready;
    fmqd_pkg::t_fmqd_job front_job;
    logic                back_valid;
    logic                back_ready;
    fmqd_pkg::t_fmqd_job back_job;

    fmqd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready),
        .o_job       (front_job)
    );

    fmqd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_job   (front_job),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_job    (back_job)
    );

    fmqd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (back_valid),
        .o_job_ready (back_ready),
        .i_job       (back_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

endmodule

`default_nettype wire

/* rtl/fmqd_front.sv */
// Front end: takes samples, checks them against the threshold, pairs them with the last sample.
`default_nettype none

module fmqd_front (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_in_valid,
    output logic                                   o_in_ready,
    input  fmqd_pkg::t_in_req                      i_in_req,
    input  wire                                    i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire [fmqd_pkg::THRESH_BITS-1:0]        i_cfg_data,
    output logic                                   o_job_valid,
    input  wire                                    i_job_ready,
    output fmqd_pkg::t_fmqd_job                    o_job
);

    logic [fmqd_pkg::THRESH_BITS-1:0]        r_threshold;
    logic signed [fmqd_pkg::SAMPLE_BITS-1:0] r_prev_i;
    logic signed [fmqd_pkg::SAMPLE_BITS-1:0] r_prev_q;
    logic [fmqd_pkg::SAMPLE_BITS-1:0]        mag_i;
    logic [fmqd_pkg::SAMPLE_BITS-1:0]        mag_q;
    logic [fmqd_pkg::CMP_BITS-1:0]           cmp_thr;
    logic                                    accept;

    always_comb begin
        mag_i = i_in_req.in_phase[fmqd_pkg::SAMPLE_BITS-1] ?
                (~i_in_req.in_phase + 1'b1) : i_in_req.in_phase;
        mag_q = i_in_req.quadrature[fmqd_pkg::SAMPLE_BITS-1] ?
                (~i_in_req.quadrature + 1'b1) : i_in_req.quadrature;
        cmp_thr = fmqd_pkg::CMP_BITS'(r_threshold);
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = i_job_ready;
    assign o_job_valid = i_in_valid;
    assign accept      = i_in_valid && i_job_ready;

    always_comb begin
        o_job.in_phase        = i_in_req.in_phase;
        o_job.quadrature      = i_in_req.quadrature;
        o_job.prev_in_phase   = r_prev_i;
        o_job.prev_quadrature = r_prev_q;
        o_job.above           = (fmqd_pkg::CMP_BITS'(mag_i) > cmp_thr) ||
                                (fmqd_pkg::CMP_BITS'(mag_q) > cmp_thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= fmqd_pkg::THRESH_RESET;
            r_prev_i    <= '0;
            r_prev_q    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_threshold <= i_cfg_data;
            end
            if (accept) begin
                r_prev_i <= i_in_req.in_phase;
                r_prev_q <= i_in_req.quadrature;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/fmqd_queue.sv */
// Two-entry queue between the front end and the arithmetic back end.
`default_nettype none

module fmqd_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push_valid,
    output logic                 o_push_ready,
    input  fmqd_pkg::t_fmqd_job  i_push_job,
    output logic                 o_pop_valid,
    input  wire                  i_pop_ready,
    output fmqd_pkg::t_fmqd_job  o_pop_job
);

    localparam int DEPTH = 2;

    fmqd_pkg::t_fmqd_job r_mem [DEPTH];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != 2'(DEPTH));
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= 2'(DEPTH)) && ((r_count == 2'd1) == (r_wr_ptr != r_rd_ptr)))
        else $error("Queue count disagrees with its pointers.");
`endif

endmodule

`default_nettype wire

/* rtl/fmqd_back.sv */
// Back end: cross products, squared magnitude, restoring divider, saturation, held value and the output register.
`default_nettype none

module fmqd_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_job_valid,
    output logic                 o_job_ready,
    input  fmqd_pkg::t_fmqd_job  i_job,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output fmqd_pkg::t_out_req   o_out_req
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [2:0] MUL_NUM_FIRST = 3'd1;
    localparam logic [2:0] MUL_NUM_LAST  = 3'd2;
    localparam logic [2:0] MUL_DEN_FIRST = 3'd3;
    localparam logic [2:0] MUL_LAST      = 3'd4;

    localparam int SB = fmqd_pkg::SAMPLE_BITS;
    localparam int PB = fmqd_pkg::PROD_BITS;
    localparam int NB = fmqd_pkg::NUM_BITS;
    localparam int RB = fmqd_pkg::REM_BITS;
    localparam int QB = fmqd_pkg::QUO_BITS;
    localparam int OB = fmqd_pkg::OUT_BITS;

    logic [1:0]                         r_state;
    logic [2:0]                         r_step;
    logic [fmqd_pkg::CNT_BITS-1:0]      r_cnt;
    logic                               r_out_valid;
    logic [OB-1:0]                      r_held;
    fmqd_pkg::t_fmqd_job                r_job;
    fmqd_pkg::t_out_req                 r_out;
    logic signed [PB-1:0]               r_prod;
    logic signed [NB-1:0]               r_num;
    logic [PB-1:0]                      r_den;
    logic [RB-1:0]                      r_rem;
    logic [RB-1:0]                      r_dvs;
    logic [QB-1:0]                      r_quo;

    logic signed [SB-1:0]               mul_a;
    logic signed [SB-1:0]               mul_b;
    logic signed [PB-1:0]               prod;
    logic signed [NB-1:0]               prod_ext;
    logic [PB-1:0]                      den_sum;
    logic [NB-1:0]                      num_abs;
    logic                               rem_ge;
    logic                               sat;
    logic [OB-1:0]                      res;
    logic                               out_free;

    always_comb begin
        case (r_step[1:0])
            2'd0: begin
                mul_a = r_job.quadrature;
                mul_b = r_job.prev_in_phase;
            end
            2'd1: begin
                mul_a = r_job.in_phase;
                mul_b = r_job.prev_quadrature;
            end
            2'd2: begin
                mul_a = r_job.in_phase;
                mul_b = r_job.in_phase;
            end
            default: begin
                mul_a = r_job.quadrature;
                mul_b = r_job.quadrature;
            end
        endcase
        prod     = mul_a * mul_b;
        prod_ext = {r_prod[PB-1], r_prod};
        den_sum  = r_den + r_prod;
        num_abs  = r_num[NB-1] ? (~r_num + 1'b1) : r_num;
        rem_ge   = (r_rem >= r_dvs);
        sat      = |r_quo[QB-1:OB-1];
        if (!r_job.above) begin
            res = r_held;
        end else if (r_num[NB-1]) begin
            res = sat ? fmqd_pkg::OUT_MIN : (~r_quo[OB-1:0] + 1'b1);
        end else begin
            res = sat ? fmqd_pkg::OUT_MAX : r_quo[OB-1:0];
        end
        out_free = !r_out_valid || i_out_ready;
    end

    assign o_job_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= 3'd0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_held      <= '0;
        end else begin
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= i_job.above ? ST_MUL : ST_DONE;
                        r_step  <= 3'd0;
                    end
                end
                ST_MUL: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == MUL_LAST) begin
                        r_state <= ST_DIV;
                        r_cnt   <= fmqd_pkg::CNT_BITS'(QB - 1);
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_held  <= res;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    r_job <= i_job;
                end
            end
            ST_MUL: begin
                if (r_step != MUL_LAST) begin
                    r_prod <= prod;
                end
                if (r_step == MUL_NUM_FIRST) begin
                    r_num <= prod_ext;
                end else if (r_step == MUL_NUM_LAST) begin
                    r_num <= r_num - prod_ext;
                end else if (r_step == MUL_DEN_FIRST) begin
                    r_den <= r_prod;
                end else if (r_step == MUL_LAST) begin
                    r_den <= den_sum;
                    r_rem <= RB'(num_abs) << fmqd_pkg::OUT_FRAC;
                    r_dvs <= RB'(den_sum) << (QB - 1);
                    r_quo <= '0;
                end
            end
            ST_DIV: begin
                if (rem_ge) begin
                    r_rem <= r_rem - r_dvs;
                end
                r_quo <= {r_quo[QB-2:0], rem_ge};
                r_dvs <= r_dvs >> 1;
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out.demod_value <= res;
                    r_out.held        <= !r_job.above;
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_dvs != '0))
        else $error("Divider runs with a zero divisor.");

    a_mul_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> r_job.above)
        else $error("Arithmetic started for a sample below the threshold.");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.demod_value == r_held))
        else $error("Pending result differs from the held value.");
`endif

endmodule

`default_nettype wire
